[rtl/npm_pkg.sv]
// Shared types and constants for the nearest point merge table.
// No dependencies.
package npm_pkg;

    localparam int COORD_W  = 24;
    localparam int RAD_W    = 23;
    localparam int TIME_W   = 63;
    localparam int DIFF_W   = 25;
    localparam int SQ_W     = 50;
    localparam int DIST_W   = 52;
    localparam int RSQ_W    = 46;
    localparam int WGT_W    = 32;
    localparam int ID_W     = 32;
    localparam int NUM_W    = 57;
    localparam int MAG_W    = 56;
    localparam int DVS_W    = 33;
    localparam int POS_W    = 3 * COORD_W;
    localparam int META_W   = WGT_W + ID_W;
    localparam int TM_W     = 2 * TIME_W;
    localparam int STATUS_W = 2;
    localparam int SLOT_O_W = 8;
    localparam int CNT_W    = 16;

    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MERGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SPAWN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_RADIUS = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_DECIDE = 10'b0000001000,
        S_FETCH  = 10'b0000010000,
        S_LOAD   = 10'b0000100000,
        S_MUL    = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_WRITE  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    // squared distance result from the scan pipeline
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [DIST_W-1:0] sum_sq;
    } dist_t;

endpackage

[rtl/nearest_point_merge_table.sv]
// Nearest point merge table: top level with control sequencer and slot RAMs.
// A reject goes straight to the output state; a spawn or full result follows a scan of
// the used slots (skipped with an empty table); a merge adds a fetch and three multiply
// and 56-step divide passes. A stall on m_ready holds the sequencer in the output state.
// Throughput: one item at a time; the next input transfers once the result is loaded.
// Reset: synchronous, active low; clears counters, sets merge_radius to 256; RAMs kept.
module nearest_point_merge_table #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [npm_pkg::RAD_W-1:0]          cfg_merge_radius,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [npm_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [npm_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [npm_pkg::COORD_W-1:0] s_pos_z,
    input  logic [npm_pkg::CNT_W-1:0]          s_desc_count,
    input  logic [npm_pkg::TIME_W-1:0]         s_first_time,
    input  logic [npm_pkg::TIME_W-1:0]         s_last_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [npm_pkg::STATUS_W-1:0]       m_status,
    output logic [npm_pkg::SLOT_O_W-1:0]       m_slot_index,
    output logic [npm_pkg::ID_W-1:0]           m_entry_id,
    output logic [npm_pkg::WGT_W-1:0]          m_source_total,
    output logic [npm_pkg::ID_W-1:0]           m_processed_total
);
    import npm_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int UW = $clog2(TABLE_SLOTS + 1);

    state_t                   state_reg;
    logic signed [COORD_W-1:0] p_reg [3];
    logic [TIME_W-1:0]        tf_reg, tl_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [RSQ_W-1:0]         rsq_reg;
    logic [UW-1:0]            used_reg, issue_reg, rcv_reg;
    logic [ID_W-1:0]          ident_reg, processed_reg;
    logic                     rd_vld_reg, rd_last_reg;
    logic [DIST_W-1:0]        best_reg, cmp_ref;
    logic                     hit_vld_reg;
    logic [AW-1:0]            hit_idx_reg, slot_reg;
    logic signed [COORD_W-1:0] old_reg [3];
    logic signed [COORD_W-1:0] new_reg [3];
    logic [WGT_W-1:0]         wgt_reg, weff, wsat;
    logic [ID_W-1:0]          id_reg, res_id_reg;
    logic [WGT_W-1:0]         res_tot_reg;
    logic [1:0]               coord_reg;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]         num_mag;
    logic                     div_go_reg, div_done;
    logic [MAG_W-1:0]         div_q;
    logic [COORD_W-1:0]       q24;
    logic [STATUS_W-1:0]      status_reg;
    logic                     m_valid_reg;
    logic                     out_load;
    logic [STATUS_W-1:0]      m_status_reg;
    logic [SLOT_O_W-1:0]      m_slot_reg;
    logic [ID_W-1:0]          m_id_reg, m_tot_reg, m_proc_reg;

    logic                     ram_en, ram_we;
    logic [AW-1:0]            ram_addr;
    logic [POS_W-1:0]         pos_wdata, pos_rdata;
    logic [META_W-1:0]        meta_wdata, meta_rdata;
    logic [TM_W-1:0]          tm_wdata, tm_rdata;
    dist_t                    dres;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    npm_ram #(.WIDTH(POS_W), .DEPTH(TABLE_SLOTS)) u_pos_ram (
        .aclk(aclk), .en(ram_en), .we(ram_we), .addr(ram_addr),
        .wdata(pos_wdata), .rdata(pos_rdata)
    );

    npm_ram #(.WIDTH(META_W), .DEPTH(TABLE_SLOTS)) u_meta_ram (
        .aclk(aclk), .en(ram_en), .we(ram_we), .addr(ram_addr),
        .wdata(meta_wdata), .rdata(meta_rdata)
    );

    // first and last seen times; first time is carried over on a merge
    npm_ram #(.WIDTH(TM_W), .DEPTH(TABLE_SLOTS)) u_time_ram (
        .aclk(aclk), .en(ram_en), .we(ram_we), .addr(ram_addr),
        .wdata(tm_wdata), .rdata(tm_rdata)
    );

    npm_dist u_dist (
        .aclk(aclk), .aresetn(aresetn), .in_vld(rd_vld_reg), .in_last(rd_last_reg),
        .stored(pos_rdata), .px(p_reg[0]), .py(p_reg[1]), .pz(p_reg[2]), .dout(dres)
    );

    npm_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .dividend(num_mag[MAG_W-1:0]), .divisor({1'b0, weff} + DVS_W'(1)),
        .done(div_done), .quotient(div_q)
    );

    always_comb begin
        weff     = (wgt_reg == '0) ? WGT_W'(1) : wgt_reg;
        wsat     = (wgt_reg == '1) ? wgt_reg : wgt_reg + 1'b1;
        num_next = $signed(old_reg[coord_reg]) * $signed({1'b0, weff})
                   + $signed(p_reg[coord_reg]);
        num_mag  = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        q24      = num_reg[NUM_W-1] ? COORD_W'(-div_q[COORD_W-1:0]) : div_q[COORD_W-1:0];
        cmp_ref  = hit_vld_reg ? best_reg : DIST_W'(rsq_reg);

        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = issue_reg[AW-1:0];
        pos_wdata  = {new_reg[0], new_reg[1], new_reg[2]};
        meta_wdata = {wsat, id_reg};
        tm_wdata   = {tf_reg, tl_reg};
        unique case (state_reg)
            S_SCAN: begin
                ram_en = (issue_reg < used_reg);
            end
            S_DECIDE: begin
                if (!hit_vld_reg && used_reg != UW'(TABLE_SLOTS)) begin
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_addr   = used_reg[AW-1:0];
                    pos_wdata  = {p_reg[0], p_reg[1], p_reg[2]};
                    meta_wdata = {WGT_W'(1), ident_reg};
                end
            end
            S_FETCH: begin
                ram_en   = 1'b1;
                ram_addr = hit_idx_reg;
            end
            S_WRITE: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = hit_idx_reg;
                tm_wdata = {tm_rdata[TM_W-1:TIME_W], tl_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rad_reg       <= RAD_W'(256);
            used_reg      <= '0;
            ident_reg     <= '0;
            processed_reg <= '0;
            rd_vld_reg    <= 1'b0;
            hit_vld_reg   <= 1'b0;
            div_go_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                rad_reg <= cfg_merge_radius;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg  <= ram_en && !ram_we && (state_reg == S_SCAN);
            rd_last_reg <= (issue_reg == used_reg - 1'b1);
            div_go_reg  <= (state_reg == S_MUL);

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        p_reg[0]    <= s_pos_x;
                        p_reg[1]    <= s_pos_y;
                        p_reg[2]    <= s_pos_z;
                        tf_reg      <= s_first_time;
                        tl_reg      <= s_last_time;
                        status_reg  <= ST_REJECT;
                        slot_reg    <= '0;
                        res_id_reg  <= '0;
                        res_tot_reg <= '0;
                        state_reg   <= (s_desc_count == '0) ? S_OUT : S_RADIUS;
                    end
                end
                S_RADIUS: begin
                    rsq_reg     <= rad_reg * rad_reg;
                    hit_vld_reg <= 1'b0;
                    issue_reg   <= '0;
                    rcv_reg     <= '0;
                    state_reg   <= (used_reg == '0) ? S_DECIDE : S_SCAN;
                end
                S_SCAN: begin
                    if (ram_en) begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (dres.vld) begin
                        rcv_reg <= rcv_reg + 1'b1;
                        // strict compare keeps the lower slot on ties
                        if (dres.sum_sq < cmp_ref) begin
                            best_reg    <= dres.sum_sq;
                            hit_vld_reg <= 1'b1;
                            hit_idx_reg <= rcv_reg[AW-1:0];
                        end
                        if (dres.last) begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (hit_vld_reg) begin
                        state_reg <= S_FETCH;
                    end else if (used_reg == UW'(TABLE_SLOTS)) begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_OUT;
                    end else begin
                        status_reg  <= ST_SPAWN;
                        slot_reg    <= used_reg[AW-1:0];
                        res_id_reg  <= ident_reg;
                        res_tot_reg <= WGT_W'(1);
                        ident_reg   <= ident_reg + 1'b1;
                        used_reg    <= used_reg + 1'b1;
                        state_reg   <= S_OUT;
                    end
                end
                S_FETCH: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    old_reg[0] <= pos_rdata[3*COORD_W-1:2*COORD_W];
                    old_reg[1] <= pos_rdata[2*COORD_W-1:COORD_W];
                    old_reg[2] <= pos_rdata[COORD_W-1:0];
                    wgt_reg    <= meta_rdata[META_W-1:ID_W];
                    id_reg     <= meta_rdata[ID_W-1:0];
                    coord_reg  <= '0;
                    state_reg  <= S_MUL;
                end
                S_MUL: begin
                    num_reg   <= num_next;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        new_reg[coord_reg] <= q24;
                        if (coord_reg == 2'd2) begin
                            state_reg <= S_WRITE;
                        end else begin
                            coord_reg <= coord_reg + 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_WRITE: begin
                    status_reg  <= ST_MERGE;
                    slot_reg    <= hit_idx_reg;
                    res_id_reg  <= id_reg;
                    res_tot_reg <= wsat;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        m_status_reg <= status_reg;
                        m_slot_reg   <= SLOT_O_W'(slot_reg);
                        m_id_reg     <= res_id_reg;
                        m_tot_reg    <= res_tot_reg;
                        if (status_reg == ST_MERGE || status_reg == ST_SPAWN) begin
                            processed_reg <= processed_reg + 1'b1;
                            m_proc_reg    <= processed_reg + 1'b1;
                        end else begin
                            m_proc_reg <= processed_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_slot_index      = m_slot_reg;
    assign m_entry_id        = m_id_reg;
    assign m_source_total    = m_tot_reg;
    assign m_processed_total = m_proc_reg;

`ifndef SYNTHESIS
    a_hit_in_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_vld_reg |-> best_reg < DIST_W'(rsq_reg))
        else $error("best distance not inside merge radius");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(TABLE_SLOTS))
        else $error("fill count beyond table size");
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");
`endif
endmodule

[rtl/npm_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module npm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end
endmodule

[rtl/npm_dist.sv]
// Three-stage squared distance pipeline: abs diff, square, sum.
// Depends on npm_pkg.
module npm_dist (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_vld,
    input  logic                                  in_last,
    input  logic [npm_pkg::POS_W-1:0]             stored,
    input  logic signed [npm_pkg::COORD_W-1:0]    px,
    input  logic signed [npm_pkg::COORD_W-1:0]    py,
    input  logic signed [npm_pkg::COORD_W-1:0]    pz,
    output npm_pkg::dist_t                        dout
);
    import npm_pkg::*;

    logic [1:0]        vld_reg, last_reg;
    logic [DIFF_W-1:0] ad_reg [3];
    logic [SQ_W-1:0]   sq_reg [3];
    logic [DIFF_W-1:0] ad_next [3];
    logic signed [DIFF_W-1:0] d [3];
    logic signed [COORD_W-1:0] s [3];
    logic signed [COORD_W-1:0] p [3];
    dist_t             out_reg;

    always_comb begin
        s[0] = stored[3*COORD_W-1:2*COORD_W];
        s[1] = stored[2*COORD_W-1:COORD_W];
        s[2] = stored[COORD_W-1:0];
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int k = 0; k < 3; k++) begin
            d[k] = DIFF_W'(s[k]) - DIFF_W'(p[k]);
            ad_next[k] = d[k][DIFF_W-1] ? DIFF_W'(-d[k]) : DIFF_W'(d[k]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            ad_reg[k] <= ad_next[k];
            sq_reg[k] <= ad_reg[k] * ad_reg[k];
        end
        out_reg.sum_sq <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        out_reg.last <= last_reg[1];
        if (!aresetn) begin
            vld_reg     <= '0;
            last_reg    <= '0;
            out_reg.vld <= 1'b0;
        end else begin
            vld_reg     <= {vld_reg[0], in_vld};
            last_reg    <= {last_reg[0], in_last};
            out_reg.vld <= vld_reg[1];
        end
    end

    assign dout = out_reg;
endmodule

[rtl/npm_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on npm_pkg.
module npm_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [npm_pkg::MAG_W-1:0]  dividend,
    input  logic [npm_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [npm_pkg::MAG_W-1:0]  quotient
);
    import npm_pkg::*;

    localparam int STEP_W = $clog2(MAG_W + 1);

    logic [DVS_W:0]    rem_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg;
    logic [DVS_W:0]    shifted, diff;
    logic              ge;

    always_comb begin
        shifted = {rem_reg[DVS_W-1:0], quo_reg[MAG_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                step_reg <= STEP_W'(MAG_W);
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff : shifted;
                quo_reg  <= {quo_reg[MAG_W-2:0], ge};
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
